>>> rtl/trigger_coincidence_detector_macros.svh
// Assertion macros for the trigger coincidence detector.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef TRIGGER_COINCIDENCE_DETECTOR_MACROS_SVH
`define TRIGGER_COINCIDENCE_DETECTOR_MACROS_SVH

// Checked on every clock edge outside reset.
`define TCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define TCD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> rtl/tcd_pkg.sv
// Shared types and constants for the trigger coincidence detector.
// No dependencies; used by the interfaces, the entry store and the top level.
package tcd_pkg;

  localparam int CHAN_W = 8;
  localparam int SECS_W = 32;
  localparam int SAMP_W = 28;
  localparam int TIME_W = 60;
  localparam int MINC_W = 5;
  localparam int WIN_W  = 28;
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic [SAMP_W-1:0] TICKS_PER_SEC = 28'd200000000;

  localparam int DEPTH_DEF        = 128;
  localparam int MAX_CHANNELS_DEF = 16;

  localparam logic [MINC_W-1:0] MIN_CHANNELS_RST = 5'd8;
  localparam logic [WIN_W-1:0]  WINDOW_RST       = 28'd2060;

  // Register select, taken from address bit 2.
  localparam logic REG_MIN_CHANNELS = 1'b0;
  localparam logic REG_WINDOW_TICKS = 1'b1;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_UNL_RD,
    ST_UNL_WR,
    ST_WALK_RD,
    ST_WALK_EV,
    ST_LINK1,
    ST_LINK2,
    ST_LINK3,
    ST_SEARCH,
    ST_OUT_RD,
    ST_OUT_EV,
    ST_IN_RD,
    ST_IN_EV,
    ST_DONE
  } state_e;

  // Where a new entry lands in the ordered list.
  typedef enum logic [1:0] {
    LK_HEAD,
    LK_TAIL,
    LK_MID
  } link_e;

  typedef struct packed {
    logic [TIME_W-1:0] ts;
    logic [CHAN_W-1:0] chan;
    logic [SECS_W-1:0] secs;
    logic [SAMP_W-1:0] samp;
  } entry_t;

  typedef struct packed {
    logic data;
    logic nxt;
    logic prv;
  } mem_we_t;

endpackage

>>> rtl/tcd_trig_if.sv
// Trigger request channel: valid/ready handshake with the trigger fields.
// Depends on tcd_pkg for the field widths.
interface tcd_trig_if
  import tcd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] channel;
  logic [SECS_W-1:0] seconds;
  logic [SAMP_W-1:0] sample;

  modport source(output valid, channel, seconds, sample, input ready);
  modport sink(input valid, channel, seconds, sample, output ready);
endinterface

>>> rtl/tcd_hit_if.sv
// Result request channel: valid/ready handshake with the coincidence report.
// Depends on tcd_pkg for the field widths.
interface tcd_hit_if
  import tcd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              detected;
  logic [CHAN_W-1:0] hit_channel;
  logic [SECS_W-1:0] hit_seconds;
  logic [SAMP_W-1:0] hit_sample;

  modport source(output valid, detected, hit_channel, hit_seconds, hit_sample, input ready);
  modport sink(input valid, detected, hit_channel, hit_seconds, hit_sample, output ready);
endinterface

>>> rtl/tcd_store.sv
// Entry store: trigger payload memory plus next and prev link memories.
// Depends on tcd_pkg; one write and one registered read per memory per cycle.
module tcd_store
  import tcd_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int IW = $clog2(DEPTH + 1)
) (
  input  logic          clk_i,
  input  mem_we_t       we_i,
  input  logic [AW-1:0] data_waddr_i,
  input  entry_t        data_wdata_i,
  input  logic [AW-1:0] nxt_waddr_i,
  input  logic [IW-1:0] nxt_wdata_i,
  input  logic [AW-1:0] prv_waddr_i,
  input  logic [IW-1:0] prv_wdata_i,
  input  logic [AW-1:0] raddr_i,
  output entry_t        rd_entry_o,
  output logic [IW-1:0] rd_nxt_o,
  output logic [IW-1:0] rd_prv_o
);

  entry_t        data_mem [DEPTH];
  logic [IW-1:0] nxt_mem  [DEPTH];
  logic [IW-1:0] prv_mem  [DEPTH];

  // Writes.
  always_ff @(posedge clk_i) begin
    if (we_i.data) begin
      data_mem[data_waddr_i] <= data_wdata_i;
    end
    if (we_i.nxt) begin
      nxt_mem[nxt_waddr_i] <= nxt_wdata_i;
    end
    if (we_i.prv) begin
      prv_mem[prv_waddr_i] <= prv_wdata_i;
    end
  end

  // Registered reads, all at one shared address.
  always_ff @(posedge clk_i) begin
    rd_entry_o <= data_mem[raddr_i];
    rd_nxt_o   <= nxt_mem[raddr_i];
    rd_prv_o   <= prv_mem[raddr_i];
  end

endmodule

>>> rtl/trigger_coincidence_detector.sv
// Per trigger: the ordering walk passes fewer than DEPTH entries, at most DEPTH start entries
// are tried, and at most DEPTH*(DEPTH-1)/2 older entries are examined over all starts; the
// report may then wait for the receiver. One trigger at a time, set by the single read port
// of the entry store; the next can be taken in the cycle after the report is registered.
// Reset: a clearing pass over every slot rebuilds the store; configuration writes are taken.
`include "trigger_coincidence_detector_macros.svh"

module trigger_coincidence_detector
  import tcd_pkg::*;
#(
  parameter int DEPTH        = DEPTH_DEF,
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  tcd_trig_if.sink          trig_i,
  tcd_hit_if.source         hit_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IW  = $clog2(DEPTH + 1);
  localparam int MCW = $clog2(MAX_CHANNELS + 1);
  localparam int NW  = ((MCW > MINC_W) ? MCW : MINC_W) + 1;
  localparam logic [IW-1:0] NONE = IW'(DEPTH);
  localparam logic [IW-1:0] LAST = IW'(DEPTH - 1);

  state_e state_q, state_d;
  link_e  lk_q, lk_sel;

  logic [IW-1:0] clr_q;
  logic [IW-1:0] newest_q, oldest_q;
  logic [IW-1:0] slot_q, run_q, stop_q, start_q, start_nxt_q;
  logic [MINC_W-1:0] min_q;
  logic [WIN_W-1:0]  win_q;

  logic [CHAN_W-1:0] in_chan_q;
  logic [SECS_W-1:0] in_secs_q;
  logic [SAMP_W-1:0] in_samp_q;
  logic [TIME_W-1:0] prod_q, t_q;
  entry_t            start_ent_q;

  logic [(2**CHAN_W)-1:0] seen_q;
  logic [NW-1:0]          cnt_q, need;
  logic                   found_q;

  logic              hv_q, det_q;
  logic [CHAN_W-1:0] hch_q;
  logic [SECS_W-1:0] hsec_q;
  logic [SAMP_W-1:0] hsmp_q;

  mem_we_t       we;
  logic [AW-1:0] data_waddr, nxt_waddr, prv_waddr, raddr;
  entry_t        data_wdata, rd_entry;
  logic [IW-1:0] nxt_wdata, prv_wdata, rd_nxt, rd_prv;

  logic          run_ok, start_ok, before_ok, oldn_ok;
  logic          out_win, is_new, hit_now, out_free, apb_wr;
  logic [TIME_W:0] win_sum;

  tcd_store #(.DEPTH(DEPTH)) u_store (
    .clk_i       (clk_i),
    .we_i        (we),
    .data_waddr_i(data_waddr),
    .data_wdata_i(data_wdata),
    .nxt_waddr_i (nxt_waddr),
    .nxt_wdata_i (nxt_wdata),
    .prv_waddr_i (prv_waddr),
    .prv_wdata_i (prv_wdata),
    .raddr_i     (raddr),
    .rd_entry_o  (rd_entry),
    .rd_nxt_o    (rd_nxt),
    .rd_prv_o    (rd_prv)
  );

  // Pointer checks and the window compare of the search step.
  assign run_ok    = run_q < NONE;
  assign start_ok  = start_q < NONE;
  assign before_ok = rd_prv < NONE;
  assign oldn_ok   = rd_prv < NONE;
  assign win_sum   = {1'b0, rd_entry.ts} + (TIME_W + 1)'(win_q);
  assign out_win   = win_sum < {1'b0, start_ent_q.ts};
  assign is_new    = !seen_q[rd_entry.chan];
  assign need      = (NW'(min_q) > NW'(MAX_CHANNELS)) ? NW'(MAX_CHANNELS) : NW'(min_q);
  assign hit_now   = is_new && ((cnt_q + NW'(2)) >= need);
  assign out_free  = !hv_q || hit_o.ready;
  assign apb_wr    = psel && penable && pwrite;

  // Placement of the new entry relative to the stop point of the ordering walk.
  always_comb begin
    if (run_q == newest_q) begin
      lk_sel = LK_HEAD;
    end else if (!run_ok) begin
      lk_sel = LK_TAIL;
    end else begin
      lk_sel = LK_MID;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:   if (clr_q == LAST) state_d = ST_IDLE;
      ST_IDLE:    if (trig_i.valid) state_d = ST_MUL;
      ST_MUL:     state_d = ST_ADD;
      ST_ADD:     state_d = ST_UNL_RD;
      ST_UNL_RD:  state_d = ST_UNL_WR;
      ST_UNL_WR:  state_d = ST_WALK_RD;
      ST_WALK_RD: state_d = run_ok ? ST_WALK_EV : ST_LINK1;
      ST_WALK_EV: state_d = (rd_entry.ts <= t_q) ? ST_LINK1 : ST_WALK_RD;
      ST_LINK1:   state_d = ST_LINK2;
      ST_LINK2:   state_d = (lk_q == LK_MID) ? ST_LINK3 : ST_SEARCH;
      ST_LINK3:   state_d = ST_SEARCH;
      ST_SEARCH:  state_d = ST_OUT_RD;
      ST_OUT_RD:  state_d = ((start_q == stop_q) || !start_ok) ? ST_DONE : ST_OUT_EV;
      ST_OUT_EV:  state_d = ST_IN_RD;
      ST_IN_RD:   state_d = run_ok ? ST_IN_EV : ST_OUT_RD;
      ST_IN_EV: begin
        priority if (out_win) begin
          state_d = ST_OUT_RD;
        end else if (hit_now) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_IN_RD;
        end
      end
      ST_DONE:    if (out_free) state_d = ST_IDLE;
      default:    state_d = ST_CLEAR;
    endcase
  end

  // Store control: reads, writes and the clearing pass.
  always_comb begin
    we         = '0;
    data_waddr = slot_q[AW-1:0];
    data_wdata = '{ts: t_q, chan: in_chan_q, secs: in_secs_q, samp: in_samp_q};
    nxt_waddr  = slot_q[AW-1:0];
    nxt_wdata  = run_q;
    prv_waddr  = slot_q[AW-1:0];
    prv_wdata  = NONE;
    raddr      = run_q[AW-1:0];
    unique case (state_q)
      ST_CLEAR: begin
        we         = '{data: 1'b1, nxt: 1'b1, prv: 1'b1};
        data_waddr = clr_q[AW-1:0];
        data_wdata = '0;
        nxt_waddr  = clr_q[AW-1:0];
        nxt_wdata  = clr_q + IW'(1);
        prv_waddr  = clr_q[AW-1:0];
        prv_wdata  = (clr_q == '0) ? NONE : (clr_q - IW'(1));
      end
      ST_UNL_RD: raddr = slot_q[AW-1:0];
      ST_UNL_WR: begin
        // Detach the old tail and fill its slot with the new trigger.
        we.data   = 1'b1;
        we.nxt    = oldn_ok;
        nxt_waddr = rd_prv[AW-1:0];
        nxt_wdata = NONE;
      end
      ST_LINK1: begin
        we.nxt = 1'b1;
        unique case (lk_sel)
          LK_HEAD: we.prv = 1'b1;
          LK_TAIL: begin
            we.prv    = 1'b1;
            prv_wdata = oldest_q;
          end
          LK_MID:  raddr = run_q[AW-1:0];
          default: we.prv = 1'b0;
        endcase
      end
      ST_LINK2: begin
        unique case (lk_q)
          LK_HEAD: begin
            we.prv    = run_ok;
            prv_waddr = run_q[AW-1:0];
            prv_wdata = slot_q;
          end
          LK_TAIL: begin
            we.nxt    = 1'b1;
            nxt_waddr = oldest_q[AW-1:0];
            nxt_wdata = slot_q;
          end
          LK_MID: begin
            we.nxt    = before_ok;
            nxt_waddr = rd_prv[AW-1:0];
            nxt_wdata = slot_q;
            we.prv    = 1'b1;
            prv_wdata = rd_prv;
          end
          default: we = '0;
        endcase
      end
      ST_LINK3: begin
        we.prv    = 1'b1;
        prv_waddr = run_q[AW-1:0];
        prv_wdata = slot_q;
      end
      ST_OUT_RD: raddr = start_q[AW-1:0];
      default:   raddr = run_q[AW-1:0];
    endcase
  end

  assign trig_i.ready = (state_q == ST_IDLE);

  // Control state, pointers and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      clr_q    <= '0;
      newest_q <= '0;
      oldest_q <= LAST;
      min_q    <= MIN_CHANNELS_RST;
      win_q    <= WINDOW_RST;
      hv_q     <= 1'b0;
      lk_q     <= LK_HEAD;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + IW'(1);
      end
      if (state_q == ST_UNL_WR) begin
        oldest_q <= rd_prv;
      end
      if (state_q == ST_LINK1) begin
        lk_q <= lk_sel;
        if (lk_sel == LK_HEAD) begin
          newest_q <= slot_q;
        end
      end
      if ((state_q == ST_LINK2) && (lk_q == LK_TAIL)) begin
        oldest_q <= slot_q;
      end
      if ((state_q == ST_DONE) && out_free) begin
        hv_q <= 1'b1;
      end else if (hit_o.ready) begin
        hv_q <= 1'b0;
      end
      if (apb_wr) begin
        if (paddr[2] == REG_WINDOW_TICKS) begin
          win_q <= pwdata[WIN_W-1:0];
        end else begin
          min_q <= pwdata[MINC_W-1:0];
        end
      end
    end
  end

  // Datapath registers of the sequencer.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        in_chan_q <= trig_i.channel;
        in_secs_q <= trig_i.seconds;
        in_samp_q <= trig_i.sample;
      end
      ST_MUL: prod_q <= in_secs_q * TICKS_PER_SEC;
      ST_ADD: begin
        t_q    <= prod_q + TIME_W'(in_samp_q);
        slot_q <= oldest_q;
      end
      ST_UNL_WR:  run_q <= newest_q;
      ST_WALK_EV: if (rd_entry.ts > t_q) run_q <= rd_nxt;
      ST_SEARCH: begin
        start_q <= newest_q;
        stop_q  <= run_q;
        found_q <= 1'b0;
      end
      ST_OUT_EV: begin
        start_ent_q <= rd_entry;
        start_nxt_q <= rd_nxt;
        run_q       <= rd_nxt;
        seen_q      <= '0;
        cnt_q       <= '0;
      end
      ST_IN_RD: if (!run_ok) start_q <= start_nxt_q;
      ST_IN_EV: begin
        priority if (out_win) begin
          start_q <= start_nxt_q;
        end else if (hit_now) begin
          found_q <= 1'b1;
        end else begin
          if (is_new) begin
            seen_q[rd_entry.chan] <= 1'b1;
            cnt_q                 <= cnt_q + NW'(1);
          end
          run_q <= rd_nxt;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          det_q  <= found_q;
          hch_q  <= found_q ? start_ent_q.chan : '0;
          hsec_q <= found_q ? start_ent_q.secs : '0;
          hsmp_q <= found_q ? start_ent_q.samp : '0;
        end
      end
      default: ;
    endcase
  end

  assign hit_o.valid       = hv_q;
  assign hit_o.detected    = det_q;
  assign hit_o.hit_channel = hch_q;
  assign hit_o.hit_seconds = hsec_q;
  assign hit_o.hit_sample  = hsmp_q;

  // Register reads.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_WINDOW_TICKS) ? APB_DW'(win_q) : APB_DW'(min_q);

  // Checks on the sequencer.
  `TCD_ASSERT(a_accept_starts, trig_i.valid && trig_i.ready |=> state_q == ST_MUL, "no multiply")
  `TCD_ASSERT(a_ptrs_valid, (newest_q < NONE) && (oldest_q < NONE), "list end out of range")
  `TCD_ASSERT(a_clear_blocks, state_q == ST_CLEAR |-> !trig_i.ready, "trigger taken in clear")
  `TCD_ASSERT(a_miss_zero, hit_o.valid && !hit_o.detected |-> hit_o.hit_channel == '0, "miss")

endmodule

>>> bench/trigger_coincidence_detector_tb.sv
// Self-checking testbench for the trigger coincidence detector.
// Drives triggers and register writes and compares every coincidence report.
// Depends on tcd_pkg, tcd_trig_if, tcd_hit_if and the detector RTL.
module trigger_coincidence_detector_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tcd_pkg::*;

  localparam int NSLOT = DEPTH_DEF;
  localparam int NCHAN = MAX_CHANNELS_DEF;
  localparam longint unsigned TICKS = 64'd200000000;

  typedef struct {
    logic              detected;
    logic [CHAN_W-1:0] channel;
    logic [SECS_W-1:0] seconds;
    logic [SAMP_W-1:0] sample;
  } report_t;

  // Tracks the trigger history and the reports still owed by the block.
  class coincidence_scoreboard;
    longint unsigned   stamp[NSLOT];
    logic [CHAN_W-1:0] chan[NSLOT];
    logic [SECS_W-1:0] secs[NSLOT];
    logic [SAMP_W-1:0] samp[NSLOT];
    int                nxt[NSLOT];
    int                prv[NSLOT];
    int                newest;
    int                oldest;
    logic [CHAN_W-1:0] seen[NCHAN];
    int unsigned       min_chan;
    longint unsigned   window;
    report_t           owed[$];
    int                errors;

    function new();
      for (int i = 0; i < NSLOT; i++) begin
        stamp[i] = 0;
        chan[i] = '0;
        secs[i] = '0;
        samp[i] = '0;
        nxt[i] = i + 1;
        prv[i] = (i == 0) ? NSLOT : i - 1;
      end
      newest = 0;
      oldest = NSLOT - 1;
      min_chan = MIN_CHANNELS_RST;
      window = WINDOW_RST;
      errors = 0;
    endfunction

    function void set_register(logic sel, logic [31:0] value);
      if (sel == REG_MIN_CHANNELS) min_chan = value[MINC_W-1:0];
      else window = value[WIN_W-1:0];
    endfunction

    // Overwrites the oldest slot and links it in time order, newest first.
    function int store_trigger(logic [CHAN_W-1:0] c, logic [SECS_W-1:0] s,
                               logic [SAMP_W-1:0] p);
      int slot;
      int run;
      int guard;
      int pre;
      longint unsigned t;
      slot = oldest;
      t = (longint'(s) * TICKS + longint'(p)) & 64'h0FFF_FFFF_FFFF_FFFF;
      oldest = prv[slot];
      if (oldest < NSLOT) nxt[oldest] = NSLOT;
      stamp[slot] = t;
      chan[slot] = c;
      secs[slot] = s;
      samp[slot] = p;
      run = newest;
      guard = 0;
      while (run < NSLOT && guard < NSLOT) begin
        if (stamp[run] <= t) break;
        run = nxt[run];
        guard++;
      end
      nxt[slot] = run;
      if (run == newest) begin
        newest = slot;
        prv[slot] = NSLOT;
        if (run < NSLOT) prv[run] = slot;
      end else if (run >= NSLOT) begin
        if (oldest < NSLOT) nxt[oldest] = slot;
        prv[slot] = oldest;
        oldest = slot;
      end else begin
        pre = prv[run];
        if (pre < NSLOT) nxt[pre] = slot;
        prv[slot] = pre;
        prv[run] = slot;
      end
      return slot;
    endfunction

    // Returns the start slot of the first coincidence, or NSLOT when none.
    function int find_start(int latest);
      int unsigned need;
      int unsigned count;
      int stop;
      int start;
      int run;
      int outer;
      int inner;
      int k;
      need = (min_chan > NCHAN) ? NCHAN : min_chan;
      stop = nxt[latest];
      start = newest;
      outer = 0;
      while (start != stop && start < NSLOT && outer < NSLOT) begin
        run = nxt[start];
        count = 0;
        inner = 0;
        while (run < NSLOT && inner < NSLOT) begin
          if (stamp[run] + window < stamp[start]) break;
          for (k = 0; k < count; k++) begin
            if (seen[k] == chan[run]) break;
          end
          if (k == count) begin
            if (count + 2 >= need) return start;
            if (count < NCHAN) begin
              seen[count] = chan[run];
              count++;
            end
          end
          run = nxt[run];
          inner++;
        end
        start = nxt[start];
        outer++;
      end
      return NSLOT;
    endfunction

    function void note_trigger(logic [CHAN_W-1:0] c, logic [SECS_W-1:0] s,
                               logic [SAMP_W-1:0] p);
      report_t r;
      int hit;
      hit = find_start(store_trigger(c, s, p));
      if (hit < NSLOT) begin
        r.detected = 1'b1;
        r.channel = chan[hit];
        r.seconds = secs[hit];
        r.sample = samp[hit];
      end else begin
        r.detected = 1'b0;
        r.channel = '0;
        r.seconds = '0;
        r.sample = '0;
      end
      owed.insert(owed.size(), r);
    endfunction

    function void check_report(report_t got);
      report_t exp;
      if (owed.size() == 0) begin
        $error("unexpected report: detected %0d channel %0d", got.detected, got.channel);
        errors++;
        return;
      end
      exp = owed.pop_front();
      if (got.detected !== exp.detected) begin
        $error("detected: expected %0d, got %0d", exp.detected, got.detected);
        errors++;
      end
      if (got.channel !== exp.channel) begin
        $error("hit_channel: expected %0d, got %0d", exp.channel, got.channel);
        errors++;
      end
      if (got.seconds !== exp.seconds) begin
        $error("hit_seconds: expected %0d, got %0d", exp.seconds, got.seconds);
        errors++;
      end
      if (got.sample !== exp.sample) begin
        $error("hit_sample: expected %0d, got %0d", exp.sample, got.sample);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  tcd_trig_if trig ();
  tcd_hit_if  hit ();

  coincidence_scoreboard sb = new();
  int unsigned send_idle = 13;
  int unsigned recv_stall = 56;
  // Running trigger time used to build clusters.
  logic [SECS_W-1:0] cur_secs = '0;
  logic [SAMP_W-1:0] cur_samp = '0;

  trigger_coincidence_detector u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .trig_i (trig.sink),
    .hit_o  (hit.source),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always #4 clk_i = ~clk_i;

  initial begin
    trig.valid = 1'b0;
    trig.channel = '0;
    trig.seconds = '0;
    trig.sample = '0;
    hit.ready = 1'b0;
  end

  // Receiver stalls at random.
  always @(negedge clk_i) begin
    hit.ready <= ($urandom_range(99) >= recv_stall);
  end

  // Accepted triggers feed the predictor; accepted reports are checked.
  always @(posedge clk_i) begin
    if (rst_ni && trig.valid && trig.ready) begin
      sb.note_trigger(trig.channel, trig.seconds, trig.sample);
    end
    if (rst_ni && hit.valid && hit.ready) begin
      sb.check_report('{hit.detected, hit.hit_channel, hit.hit_seconds, hit.hit_sample});
    end
  end

  task automatic write_register(logic sel, logic [31:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 2'b00};
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_register(sel, value);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic send_trigger(logic [CHAN_W-1:0] c, logic [SECS_W-1:0] s,
                              logic [SAMP_W-1:0] p);
    while ($urandom_range(99) < send_idle) begin
      @(negedge clk_i);
      trig.valid <= 1'b0;
    end
    @(negedge clk_i);
    trig.valid <= 1'b1;
    trig.channel <= c;
    trig.seconds <= s;
    trig.sample <= p;
    do @(posedge clk_i); while (!trig.ready);
  endtask

  // Lowers valid and waits until every report has come back.
  task automatic drain();
    @(negedge clk_i);
    trig.valid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Mostly clustered triggers on few channels; some full-range noise.
  task automatic send_random(int n, int unsigned step_max);
    int unsigned d;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) begin
        send_trigger(CHAN_W'($urandom_range(255)), $urandom,
                     SAMP_W'($urandom_range(28'hFFFFFFF)));
      end else begin
        d = $urandom_range(step_max);
        if (cur_samp + d >= 200000000) begin
          cur_samp = SAMP_W'(cur_samp + d - 200000000);
          cur_secs++;
        end else begin
          cur_samp = SAMP_W'(cur_samp + d);
        end
        send_trigger(CHAN_W'($urandom_range(19)), cur_secs, cur_samp);
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: default registers, triggers that meet the never-written entries.
    send_trigger(8'd0, 32'd0, 28'd0);
    for (int c = 1; c < 8; c++) send_trigger(CHAN_W'(c), 32'd0, 28'(c * 100));
    send_trigger(8'd255, 32'hFFFFFFFF, 28'hFFFFFFF);
    send_trigger(8'd0, 32'd0, 28'd199999999);
    send_trigger(8'd170, 32'h55555555, 28'hAAAAAAA);
    send_trigger(8'd85, 32'hAAAAAAAA, 28'h5555555);
    drain();

    // Threshold of zero and one, zero window with equal timestamps.
    write_register(REG_MIN_CHANNELS, 32'd0);
    write_register(REG_WINDOW_TICKS, 32'd0);
    send_trigger(8'd1, 32'd7, 28'd500);
    send_trigger(8'd2, 32'd7, 28'd500);
    send_trigger(8'd2, 32'd7, 28'd500);
    drain();
    write_register(REG_MIN_CHANNELS, 32'd1);
    send_trigger(8'd3, 32'd7, 28'd500);
    send_trigger(8'd4, 32'd7, 28'd499);
    drain();

    // Threshold above the channel limit saturates.
    write_register(REG_MIN_CHANNELS, 32'd31);
    write_register(REG_WINDOW_TICKS, 32'd50000);
    cur_secs = 32'd9;
    cur_samp = 28'd199990000;
    for (int c = 0; c < 6; c++) send_random(1, 3000);
    drain();

    write_register(REG_MIN_CHANNELS, 32'd3);
    write_register(REG_WINDOW_TICKS, 32'd5000);
    send_random(25, 3000);
    drain();

    send_idle = 56;
    recv_stall = 13;
    write_register(REG_MIN_CHANNELS, 32'd2);
    write_register(REG_WINDOW_TICKS, 32'd1000);
    send_random(25, 1500);
    drain();

    // Widest window, highest threshold: the search covers the whole store.
    send_idle = 0;
    recv_stall = 0;
    write_register(REG_MIN_CHANNELS, 32'd16);
    write_register(REG_WINDOW_TICKS, 32'h0FFFFFFF);
    send_random(10, 500000);
    drain();
    write_register(REG_MIN_CHANNELS, 32'd5);
    write_register(REG_WINDOW_TICKS, 32'd2000);
    send_random(25, 800);
    drain();

    repeat (100) @(posedge clk_i);
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("trigger_coincidence_detector_tb OK");
    end else begin
      $display("trigger_coincidence_detector_tb NOT OK");
    end
    $finish;
  end

  // Run limit well above the slowest correct run.
  initial begin
    #200ms;
    $display("trigger_coincidence_detector_tb NOT OK");
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/tcd_pkg.sv
rtl/tcd_trig_if.sv
rtl/tcd_hit_if.sv
rtl/tcd_store.sv
rtl/trigger_coincidence_detector.sv
bench/trigger_coincidence_detector_tb.sv
